@@ sv/mipmap_pyramid_box_filter_core_defines.svh @@
// ---------------------------------------------------------------------------
// mipmap box filter assertion macros
// shared property forms for the core checks
// ---------------------------------------------------------------------------
`ifndef MIPMAP_PYRAMID_BOX_FILTER_CORE_DEFINES_SVH
`define MIPMAP_PYRAMID_BOX_FILTER_CORE_DEFINES_SVH

// same-cycle implication
`define MPBF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MPBF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/mpbf_pkg.sv @@
// ---------------------------------------------------------------------------
// mpbf_pkg
// shared types and constants of the mipmap box filter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mpbf_pkg;

  localparam int MAX_WIDTH      = 4096;
  localparam int MAX_LEVELS     = 10;
  localparam int MIN_LEVEL_SIZE = 4;
  localparam int ADDR_W         = 12;
  localparam int FIFO_DEPTH     = 16;
  localparam int FIFO_PTR_W     = 4;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_MIPMAP_ENABLE = 2'd2,
    REG_FOUR_CHANNEL  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LVL,
    ST_AVG
  } st_t;

  typedef struct packed {
    logic [17:0] c3;
    logic [17:0] c2;
    logic [17:0] c1;
    logic [17:0] c0;
  } quad_t;

  typedef struct packed {
    logic [15:0] c3;
    logic [15:0] c2;
    logic [15:0] c1;
    logic [15:0] c0;
  } texel_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    quad_t             wdata;
  } ram_req_t;

  typedef struct packed {
    logic [3:0]  level;
    logic [11:0] column;
    logic [11:0] row;
    texel_t      comp;
    logic        run_last;
  } res_t;

  typedef struct packed {
    logic [12:0] width;
    logic [12:0] height;
    logic [3:0]  num_levels;
    logic        four_channel;
    logic        restart;
  } geom_t;

  typedef struct packed {
    logic idle;
    logic avg;
  } seq_stat_t;

endpackage

@@ sv/mpbf_if.sv @@
// ---------------------------------------------------------------------------
// mpbf_if
// pixel and texel channel interfaces
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mpbf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_first;
  logic [7:0] byte_second;
  logic [7:0] byte_third;
  logic [7:0] byte_fourth;
  modport source(output valid, byte_first, byte_second, byte_third, byte_fourth,
                 input ready);
  modport sink(input valid, byte_first, byte_second, byte_third, byte_fourth,
               output ready);
endinterface

interface mpbf_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  level;
  logic [11:0] column;
  logic [11:0] row;
  logic [15:0] comp_red;
  logic [15:0] comp_green;
  logic [15:0] comp_blue;
  logic [15:0] comp_alpha;
  logic        run_last;
  modport source(output valid, level, column, row, comp_red, comp_green, comp_blue,
                 comp_alpha, run_last, input ready);
  modport sink(input valid, level, column, row, comp_red, comp_green, comp_blue,
               comp_alpha, run_last, output ready);
endinterface

@@ sv/mipmap_pyramid_box_filter_core.sv @@
// the first texel of a pixel is queued from ST_LVL, which follows its transaction, once the queue is not full
// a new pixel is taken only in ST_IDLE, once the previous pixel's level steps end
//   (one line buffer port: write or read-modify per level step)
// results drain through a 16-entry queue; the sequencer stalls when it fills
// reset: synchronous, active low; positions to zero, registers to 256/256/1/1
// ---------------------------------------------------------------------------
// mipmap_pyramid_box_filter_core
// raster pixel stream to mip texel stream with 2x2 box filtering
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mipmap_pyramid_box_filter_core_defines.svh"

module mipmap_pyramid_box_filter_core (
  input  logic          clk,
  input  logic          rst_n,
  mpbf_in_if.sink       in_ch,
  mpbf_out_if.source    out_ch,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [12:0]   cfg_wdata
);

  logic [12:0] width_r, height_r;
  logic        mip_r, four_r;
  logic [12:0] w_cl, h_cl;
  logic [3:0]  nlev;
  logic        in_fire, seq_idle, push, fifo_full;

  mpbf_pkg::geom_t     geom;
  mpbf_pkg::texel_t    in_texel;
  mpbf_pkg::ram_req_t  ram_req;
  mpbf_pkg::quad_t     ram_rdata;
  mpbf_pkg::res_t      push_data, pop_data;
  mpbf_pkg::seq_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 13'd256;
      height_r <= 13'd256;
      mip_r    <= 1'b1;
      four_r   <= 1'b1;
    end else if (cfg_we) begin
      unique case (mpbf_pkg::reg_idx_t'(cfg_index))
        mpbf_pkg::REG_IMAGE_WIDTH:   width_r  <= cfg_wdata;
        mpbf_pkg::REG_IMAGE_HEIGHT:  height_r <= cfg_wdata;
        mpbf_pkg::REG_MIPMAP_ENABLE: mip_r    <= cfg_wdata[0];
        mpbf_pkg::REG_FOUR_CHANNEL:  four_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_cl = (width_r == '0) ? 13'd1 :
           (width_r > 13'(mpbf_pkg::MAX_WIDTH)) ? 13'(mpbf_pkg::MAX_WIDTH) : width_r;
    h_cl = (height_r == '0) ? 13'd1 :
           (height_r > 13'(mpbf_pkg::MAX_WIDTH)) ? 13'(mpbf_pkg::MAX_WIDTH) : height_r;
    nlev = 4'd1;
    if (mip_r) begin
      for (int i = 0; i < mpbf_pkg::MAX_LEVELS; i++) begin
        if ((w_cl >> i) > 13'(mpbf_pkg::MIN_LEVEL_SIZE) &&
            (h_cl >> i) > 13'(mpbf_pkg::MIN_LEVEL_SIZE)) begin
          nlev = nlev + 4'd1;
        end
      end
    end
  end

  assign geom = '{width: w_cl, height: h_cl, num_levels: nlev,
                  four_channel: four_r, restart: cfg_we};

  assign in_ch.ready = seq_idle;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_texel.c0 = {in_ch.byte_third, 8'h00};
  assign in_texel.c1 = {in_ch.byte_second, 8'h00};
  assign in_texel.c2 = {in_ch.byte_first, 8'h00};
  assign in_texel.c3 = four_r ? {in_ch.byte_fourth, 8'h00} : {in_ch.byte_first, 8'h00};

  mpbf_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .in_fire   (in_fire),
    .in_texel  (in_texel),
    .idle      (seq_idle),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .push      (push),
    .push_data (push_data),
    .fifo_full (fifo_full),
    .stat      (stat)
  );

  mpbf_pair_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  mpbf_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop_valid (out_ch.valid),
    .pop_ready (out_ch.ready),
    .pop_data  (pop_data)
  );

  assign out_ch.level      = pop_data.level;
  assign out_ch.column     = pop_data.column;
  assign out_ch.row        = pop_data.row;
  assign out_ch.comp_red   = pop_data.comp.c0;
  assign out_ch.comp_green = pop_data.comp.c1;
  assign out_ch.comp_blue  = pop_data.comp.c2;
  assign out_ch.comp_alpha = pop_data.comp.c3;
  assign out_ch.run_last   = pop_data.run_last;

  `MPBF_ASSERT_NEXT(a_one_pixel_at_a_time, in_fire, !in_ch.ready, "pixel taken while busy")
  `MPBF_ASSERT_NEXT(a_avg_single_cycle, stat.avg, !stat.avg, "average step repeated")
  `MPBF_ASSERT_NOW(a_no_access_when_idle, stat.idle, !ram_req.we && !ram_req.re, "idle access")

endmodule

@@ sv/mpbf_pair_ram.sv @@
// ---------------------------------------------------------------------------
// mpbf_pair_ram
// single-port line buffer of horizontal pair sums, registered read
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpbf_pair_ram (
  input  logic              clk,
  input  mpbf_pkg::ram_req_t req,
  output mpbf_pkg::quad_t   rdata
);

  mpbf_pkg::quad_t mem [mpbf_pkg::MAX_WIDTH];
  mpbf_pkg::quad_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/mpbf_out_fifo.sv @@
// ---------------------------------------------------------------------------
// mpbf_out_fifo
// result queue between the level sequencer and the texel channel
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpbf_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mpbf_pkg::res_t      push_data,
  output logic                full,
  output logic                pop_valid,
  input  logic                pop_ready,
  output mpbf_pkg::res_t      pop_data
);

  mpbf_pkg::res_t                       mem [mpbf_pkg::FIFO_DEPTH];
  logic [mpbf_pkg::FIFO_PTR_W-1:0]      wr_r, wr_nxt, rd_r, rd_nxt;
  logic [mpbf_pkg::FIFO_PTR_W:0]        cnt_r, cnt_nxt;
  logic                                 do_push, do_pop;

  assign full      = (cnt_r == (mpbf_pkg::FIFO_PTR_W+1)'(mpbf_pkg::FIFO_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem[rd_r];
  assign do_push   = push && !full;
  assign do_pop    = pop_valid && pop_ready;

  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= push_data;
    end
  end

endmodule

@@ sv/mpbf_seq.sv @@
// ---------------------------------------------------------------------------
// mpbf_seq
// per-pixel level sequencer: emits texels and cascades 2x2 averages
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpbf_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  mpbf_pkg::geom_t     geom,
  input  logic                in_fire,
  input  mpbf_pkg::texel_t    in_texel,
  output logic                idle,
  output mpbf_pkg::ram_req_t  ram_req,
  input  mpbf_pkg::quad_t     ram_rdata,
  output logic                push,
  output mpbf_pkg::res_t      push_data,
  input  logic                fifo_full,
  output mpbf_pkg::seq_stat_t stat
);

  localparam int NLV = mpbf_pkg::MAX_LEVELS + 1;

  mpbf_pkg::st_t    state_r, state_nxt;
  logic [3:0]       k_r, k_nxt;
  logic [12:0]      base_r, base_nxt;
  logic             fend_r, fend_nxt;
  mpbf_pkg::texel_t v_r, v_nxt;
  mpbf_pkg::quad_t  s_r, s_nxt;
  logic [11:0]      col_r [NLV];
  logic [11:0]      row_r [NLV];
  mpbf_pkg::texel_t pend_r [mpbf_pkg::MAX_LEVELS];

  logic [11:0]      x, y;
  logic [12:0]      xn, yn, wk, hk, wk1, hk1, idx;
  logic [11:0]      p;
  logic             wrap, brk, last_lvl, step, clr_pos, pend_we;
  mpbf_pkg::quad_t  s;
  mpbf_pkg::texel_t pend;
  logic [18:0]      a0, a1, a2, a3;

  assign x    = col_r[k_r];
  assign y    = row_r[k_r];
  assign pend = (k_r < 4'(mpbf_pkg::MAX_LEVELS)) ? pend_r[k_r] : '0;
  assign wk   = geom.width >> k_r;
  assign hk   = geom.height >> k_r;
  assign wk1  = geom.width >> (k_r + 4'd1);
  assign hk1  = geom.height >> (k_r + 4'd1);
  assign xn   = {1'b0, x} + 13'd1;
  assign yn   = {1'b0, y} + 13'd1;
  assign wrap = (xn >= wk);
  assign p    = {1'b0, x[11:1]};
  assign idx  = base_r + {1'b0, p};
  assign step = (state_r == mpbf_pkg::ST_LVL) && !fifo_full;
  assign last_lvl = ({1'b0, k_r} + 5'd1 >= {1'b0, geom.num_levels});

  assign s.c0 = {2'b0, pend.c0} + {2'b0, v_r.c0};
  assign s.c1 = {2'b0, pend.c1} + {2'b0, v_r.c1};
  assign s.c2 = {2'b0, pend.c2} + {2'b0, v_r.c2};
  assign s.c3 = {2'b0, pend.c3} + {2'b0, v_r.c3};

  assign a0 = {1'b0, ram_rdata.c0} + {1'b0, s_r.c0};
  assign a1 = {1'b0, ram_rdata.c1} + {1'b0, s_r.c1};
  assign a2 = {1'b0, ram_rdata.c2} + {1'b0, s_r.c2};
  assign a3 = {1'b0, ram_rdata.c3} + {1'b0, s_r.c3};

  // cascade decision for the current level
  always_comb begin
    brk     = 1'b1;
    pend_we = 1'b0;
    ram_req = '0;
    ram_req.addr  = idx[11:0];
    ram_req.wdata = s;
    if (step && !last_lvl) begin
      if (!x[0]) begin
        pend_we = 1'b1;
      end else if ({1'b0, p} >= wk1) begin
        brk = 1'b1;
      end else if (idx[12]) begin
        brk = 1'b1;
      end else if (!y[0]) begin
        ram_req.we = 1'b1;
      end else if ({2'b0, y[11:1]} >= hk1) begin
        brk = 1'b1;
      end else begin
        ram_req.re = 1'b1;
        brk        = 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mpbf_pkg::ST_IDLE: if (in_fire) state_nxt = mpbf_pkg::ST_LVL;
      mpbf_pkg::ST_LVL:  if (step) state_nxt = brk ? mpbf_pkg::ST_IDLE : mpbf_pkg::ST_AVG;
      mpbf_pkg::ST_AVG:  state_nxt = mpbf_pkg::ST_LVL;
      default:           state_nxt = mpbf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    k_nxt    = k_r;
    base_nxt = base_r;
    fend_nxt = fend_r;
    v_nxt    = v_r;
    s_nxt    = s_r;
    clr_pos  = geom.restart;
    unique case (state_r)
      mpbf_pkg::ST_IDLE: begin
        if (in_fire) begin
          k_nxt    = '0;
          base_nxt = '0;
          fend_nxt = 1'b0;
          v_nxt    = in_texel;
        end
      end
      mpbf_pkg::ST_LVL: begin
        if (step) begin
          s_nxt = s;
          if (k_r == '0 && wrap && yn >= hk) begin
            fend_nxt = 1'b1;
          end
          if (brk && (fend_r || (k_r == '0 && wrap && yn >= hk))) begin
            clr_pos = 1'b1;
          end
        end
      end
      mpbf_pkg::ST_AVG: begin
        v_nxt.c0 = a0[17:2];
        v_nxt.c1 = a1[17:2];
        v_nxt.c2 = a2[17:2];
        v_nxt.c3 = a3[17:2];
        k_nxt    = k_r + 4'd1;
        base_nxt = base_r + wk1;
      end
      default: ;
    endcase
  end

  assign idle      = (state_r == mpbf_pkg::ST_IDLE);
  assign stat.idle = idle;
  assign stat.avg  = (state_r == mpbf_pkg::ST_AVG);
  assign push      = step;
  assign push_data = '{level: k_r, column: x, row: y, comp: v_r, run_last: brk};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpbf_pkg::ST_IDLE;
      fend_r  <= 1'b0;
      for (int i = 0; i < NLV; i++) begin
        col_r[i] <= '0;
        row_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      fend_r  <= fend_nxt;
      if (clr_pos) begin
        for (int i = 0; i < NLV; i++) begin
          col_r[i] <= '0;
          row_r[i] <= '0;
        end
      end else if (step) begin
        if (wrap) begin
          col_r[k_r] <= '0;
          row_r[k_r] <= yn[11:0];
        end else begin
          col_r[k_r] <= xn[11:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    base_r <= base_nxt;
    v_r    <= v_nxt;
    s_r    <= s_nxt;
    if (pend_we && k_r < 4'(mpbf_pkg::MAX_LEVELS)) begin
      pend_r[k_r] <= v_r;
    end
  end

endmodule
